/* hdl/tun_pkg.sv */
// Shared types, widths and helpers for the triangle unit normal pipeline.
package tun_pkg;

  // Field widths
  localparam int COORD_W   = 24;               // vertex coordinate, Q12.12
  localparam int FRAC_BITS = 14;               // fraction bits of the normal
  localparam int NORM_W    = 16;               // normal component field width

  // Derived datapath widths
  localparam int EDGE_W    = COORD_W + 1;      // v2 - v0 and friends
  localparam int PROD_W    = 2 * EDGE_W;       // edge * edge
  localparam int CROSS_W   = PROD_W + 1;       // difference of two products
  localparam int MAG_W     = 2 * EDGE_W;       // |cross component|
  localparam int HALF_W    = EDGE_W;           // low half of the magnitude
  localparam int HI_W      = MAG_W - HALF_W;   // high half of the magnitude
  localparam int SQ_W      = 2 * MAG_W;        // component squared
  localparam int SUM_W     = SQ_W + 2;         // sum of three squares
  localparam int DIV_STEPS = 2 * FRAC_BITS + 2;
  localparam int QUO_W     = DIV_STEPS + 1;    // floor(c^2 * 4^(F+1) / s)
  localparam int ROOT_W    = FRAC_BITS + 2;    // isqrt of the quotient
  localparam int TERM_W    = 2 * ROOT_W + 1;   // square root trial term
  localparam int VAL_W     = FRAC_BITS + 2;    // signed rounded magnitude

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef logic [QUO_W-1:0]          quo_t;
  typedef logic [ROOT_W-1:0]         root_t;
  typedef logic signed [NORM_W-1:0]  normal_t;

  // One triangle
  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
  } in_word_t;

  // Cross product front end result: squares, their sum, signs
  typedef struct packed {
    sq_t [2:0]  sq;
    sum_t       s;
    logic [2:0] neg;
    logic       degen;
  } cross_res_t;

  // Flags that ride along each component lane
  typedef struct packed {
    logic neg;
    logic degen;
  } side_t;

  // One result word
  typedef struct packed {
    normal_t x;
    normal_t y;
    normal_t z;
    logic    degen;
  } result_t;

  // Next component index, cyclic over x, y, z
  function automatic int next3(input int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  // m = isqrt(floor(4 c^2 2^2F / s)); rounded magnitude is floor((m + 1) / 2)
  function automatic normal_t make_normal(input root_t m, input side_t sd);
    logic [ROOT_W:0]         inc;
    root_t                   t;
    root_t                   lim;
    logic signed [VAL_W-1:0] v;
    inc = {1'b0, m} + {{ROOT_W{1'b0}}, 1'b1};
    t   = inc[ROOT_W:1];
    lim = {2'b01, {FRAC_BITS{1'b0}}};
    if (t > lim) begin
      t = lim;
    end
    v = sd.neg ? -$signed(t) : $signed(t);
    if (sd.degen) begin
      v = '0;
    end
    return normal_t'(v);
  endfunction

endpackage

/* hdl/tun_if.sv */
// Valid/ready channel interfaces for triangle words in and normal words out.
interface tun_in_if;
  logic            valid;
  logic            ready;
  tun_pkg::coord_t v0_x;
  tun_pkg::coord_t v0_y;
  tun_pkg::coord_t v0_z;
  tun_pkg::coord_t v1_x;
  tun_pkg::coord_t v1_y;
  tun_pkg::coord_t v1_z;
  tun_pkg::coord_t v2_x;
  tun_pkg::coord_t v2_y;
  tun_pkg::coord_t v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tun_out_if;
  logic             valid;
  logic             ready;
  tun_pkg::normal_t normal_x;
  tun_pkg::normal_t normal_y;
  tun_pkg::normal_t normal_z;
  logic             degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

/* hdl/tun_cross.sv */
// Front end: edges, exact cross product, squared components and their sum.
module tun_cross (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  tun_pkg::in_word_t   in_word,
  output logic                out_valid,
  output tun_pkg::cross_res_t res
);
  localparam int NSTG = 7;

  logic [NSTG-1:0] vld_r;

  tun_pkg::edge_t  a_r [3];
  tun_pkg::edge_t  b_r [3];
  tun_pkg::prod_t  pp_r [3];
  tun_pkg::prod_t  pn_r [3];
  tun_pkg::cross_t c_r [3];
  tun_pkg::mag_t   mag_r [3];
  logic [2*tun_pkg::HI_W-1:0]               hh_r [3];
  logic [tun_pkg::HI_W+tun_pkg::HALF_W-1:0] hl_r [3];
  logic [2*tun_pkg::HALF_W-1:0]             ll_r [3];
  tun_pkg::sq_t    sq6_r [3];
  tun_pkg::sq_t    sq7_r [3];
  logic            neg4_r [3];
  logic            neg5_r [3];
  logic            neg6_r [3];
  logic            neg7_r [3];
  tun_pkg::sum_t   sum_r;
  logic            degen_r;
  tun_pkg::cross_t c_abs [3];

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_abs[i] = c_r[i][tun_pkg::CROSS_W-1] ? -c_r[i] : c_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: edge A = v2 - v0, edge B = v1 - v0
      a_r[0] <= tun_pkg::edge_t'(in_word.v2_x) - tun_pkg::edge_t'(in_word.v0_x);
      a_r[1] <= tun_pkg::edge_t'(in_word.v2_y) - tun_pkg::edge_t'(in_word.v0_y);
      a_r[2] <= tun_pkg::edge_t'(in_word.v2_z) - tun_pkg::edge_t'(in_word.v0_z);
      b_r[0] <= tun_pkg::edge_t'(in_word.v1_x) - tun_pkg::edge_t'(in_word.v0_x);
      b_r[1] <= tun_pkg::edge_t'(in_word.v1_y) - tun_pkg::edge_t'(in_word.v0_y);
      b_r[2] <= tun_pkg::edge_t'(in_word.v1_z) - tun_pkg::edge_t'(in_word.v0_z);
      for (int i = 0; i < 3; i++) begin
        // Stage 2: the two products of each cross component
        pp_r[i] <= a_r[tun_pkg::next3(i)] * b_r[tun_pkg::next3(tun_pkg::next3(i))];
        pn_r[i] <= a_r[tun_pkg::next3(tun_pkg::next3(i))] * b_r[tun_pkg::next3(i)];
        // Stage 3: exact difference
        c_r[i] <= tun_pkg::cross_t'(pp_r[i]) - tun_pkg::cross_t'(pn_r[i]);
        // Stage 4: sign and magnitude
        neg4_r[i] <= c_r[i][tun_pkg::CROSS_W-1];
        mag_r[i]  <= c_abs[i][tun_pkg::MAG_W-1:0];
        // Stage 5: partial products of the square
        hh_r[i] <= mag_r[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                 * mag_r[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
        hl_r[i] <= mag_r[i][tun_pkg::MAG_W-1:tun_pkg::HALF_W]
                 * mag_r[i][tun_pkg::HALF_W-1:0];
        ll_r[i] <= mag_r[i][tun_pkg::HALF_W-1:0] * mag_r[i][tun_pkg::HALF_W-1:0];
        neg5_r[i] <= neg4_r[i];
        // Stage 6: assemble the square
        sq6_r[i] <= (tun_pkg::sq_t'(hh_r[i]) << (2 * tun_pkg::HALF_W))
                  + (tun_pkg::sq_t'(hl_r[i]) << (tun_pkg::HALF_W + 1))
                  + tun_pkg::sq_t'(ll_r[i]);
        neg6_r[i] <= neg5_r[i];
        sq7_r[i]  <= sq6_r[i];
        neg7_r[i] <= neg6_r[i];
      end
      // Stage 7: squared length
      sum_r   <= tun_pkg::sum_t'(sq6_r[0]) + tun_pkg::sum_t'(sq6_r[1])
               + tun_pkg::sum_t'(sq6_r[2]);
      degen_r <= ~|{sq6_r[0], sq6_r[1], sq6_r[2]};
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign res.sq    = {sq7_r[2], sq7_r[1], sq7_r[0]};
  assign res.s     = sum_r;
  assign res.neg   = {neg7_r[2], neg7_r[1], neg7_r[0]};
  assign res.degen = degen_r;

endmodule

/* hdl/tun_div.sv */
// Pipelined restoring divider: floor(c^2 * 4^(F+1) / s), one quotient bit per stage.
module tun_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tun_pkg::sq_t   num,
  input  tun_pkg::sum_t  den,
  input  tun_pkg::side_t side_in,
  output logic           out_valid,
  output tun_pkg::quo_t  quo,
  output tun_pkg::side_t side_out
);
  localparam int NST = tun_pkg::DIV_STEPS + 1;

  logic [NST-1:0] vld_r;
  tun_pkg::sum_t  rem_r [NST];
  tun_pkg::sum_t  rem_nxt [NST];
  tun_pkg::quo_t  quo_r [NST];
  tun_pkg::quo_t  quo_nxt [NST];
  tun_pkg::sum_t  den_r [NST];
  tun_pkg::side_t sd_r [NST];

  // Compare and subtract per stage
  always_comb begin
    logic [tun_pkg::SUM_W:0] r2;
    logic [tun_pkg::SUM_W:0] dif;
    logic                    ge;
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        // integer part: 1 only when c^2 equals s
        r2  = {1'b0, tun_pkg::sum_t'(num)};
        dif = r2 - {1'b0, den};
        ge  = r2 >= {1'b0, den};
        quo_nxt[k] = tun_pkg::quo_t'(ge);
      end else begin
        r2  = {rem_r[k-1], 1'b0};
        dif = r2 - {1'b0, den_r[k-1]};
        ge  = r2 >= {1'b0, den_r[k-1]};
        quo_nxt[k] = {quo_r[k-1][tun_pkg::QUO_W-2:0], ge};
      end
      rem_nxt[k] = ge ? dif[tun_pkg::SUM_W-1:0] : r2[tun_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= (k == 0) ? den : den_r[k-1];
        sd_r[k]  <= (k == 0) ? side_in : sd_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign quo       = quo_r[NST-1];
  assign side_out  = sd_r[NST-1];

endmodule

/* hdl/tun_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module tun_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  tun_pkg::quo_t  rad,
  input  tun_pkg::side_t side_in,
  output logic           out_valid,
  output tun_pkg::root_t root,
  output tun_pkg::side_t side_out
);
  localparam int NST = tun_pkg::ROOT_W;

  logic [NST-1:0] vld_r;
  tun_pkg::quo_t  rm_r [NST];
  tun_pkg::quo_t  rm_nxt [NST];
  tun_pkg::root_t root_r [NST];
  tun_pkg::root_t root_nxt [NST];
  tun_pkg::side_t sd_r [NST];

  // Try root bit b: take it if remainder >= 2^(b+1)*root + 4^b
  always_comb begin
    tun_pkg::quo_t            rm_p;
    tun_pkg::root_t           rt_p;
    logic [tun_pkg::TERM_W-1:0] term;
    logic [tun_pkg::TERM_W-1:0] rm_x;
    logic                     ge;
    for (int k = 0; k < NST; k++) begin
      rm_p = (k == 0) ? rad : rm_r[k-1];
      rt_p = (k == 0) ? '0 : root_r[k-1];
      rm_x = tun_pkg::TERM_W'(rm_p);
      term = (tun_pkg::TERM_W'(rt_p) << (NST - k))
           + (tun_pkg::TERM_W'(1) << (2 * (NST - 1 - k)));
      ge   = rm_x >= term;
      rm_nxt[k]   = ge ? tun_pkg::QUO_W'(rm_x - term) : rm_p;
      root_nxt[k] = ge ? (rt_p | (tun_pkg::root_t'(1) << (NST - 1 - k))) : rt_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) begin
        rm_r[k]   <= rm_nxt[k];
        root_r[k] <= root_nxt[k];
        sd_r[k]   <= (k == 0) ? side_in : sd_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign root      = root_r[NST-1];
  assign side_out  = sd_r[NST-1];

endmodule

/* hdl/tun_obuf.sv */
// Two-word output buffer; decouples the pipeline from the result receiver.
module tun_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tun_pkg::result_t   wdata,
  output logic               full,
  tun_out_if.source          out_nrm
);
  localparam logic [1:0] DEPTH = 2'd2;

  tun_pkg::result_t mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             pop;

  assign pop  = out_nrm.valid & out_nrm.ready;
  assign full = (cnt_r == DEPTH);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  assign out_nrm.valid      = (cnt_r != 2'd0);
  assign out_nrm.normal_x   = mem_r[rptr_r].x;
  assign out_nrm.normal_y   = mem_r[rptr_r].y;
  assign out_nrm.normal_z   = mem_r[rptr_r].z;
  assign out_nrm.degenerate = mem_r[rptr_r].degen;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("write into a full output buffer");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("fill count missed a write");

  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("fill count missed a read");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_nrm.valid && out_nrm.degenerate) |->
      (out_nrm.normal_x == '0 && out_nrm.normal_y == '0 && out_nrm.normal_z == '0))
    else $error("degenerate word with nonzero normal");

endmodule

/* hdl/triangle_unit_normal_top.sv */
// Top level of the triangle unit normal pipeline.
//
// in_tri carries one triangle per word: three vertices, signed Q12.12.
// out_nrm carries the unit normal (A x B)/|A x B| with A = v2 - v0 and
// B = v1 - v0, each component signed Q1.14, rounded to nearest with ties
// away from zero and clamped to +/-1.0. A triangle whose cross product is
// zero gives a zero normal with degenerate set.
// Throughput: one triangle per clock while the output buffer has room. An
// accepted input word passes 7 cross product stages, 31 divider stages,
// 16 square root stages and one buffer write on its way to out_nrm.
// The result is exact: each lane divides c^2 * 4^15 by the squared length,
// one quotient bit per stage, then takes the integer square root of that.
// Reset (rst_n low, synchronous) empties the pipeline and the buffer.
// A two-word output buffer sits in front of out_nrm; when it fills while
// the receiver stalls, in_tri.ready drops and every stage holds its word.
module triangle_unit_normal_top (
  input  logic      clk,
  input  logic      rst_n,
  tun_in_if.sink    in_tri,
  tun_out_if.source out_nrm
);
  logic                en;
  logic                full;
  tun_pkg::in_word_t   in_word;
  logic                cr_valid;
  tun_pkg::cross_res_t cres;
  logic [2:0]          dv;
  logic [2:0]          sv;
  tun_pkg::quo_t       quo [3];
  tun_pkg::side_t      dside [3];
  tun_pkg::root_t      root [3];
  tun_pkg::side_t      sside [3];
  tun_pkg::result_t    wdata;
  logic                push;

  // Whole pipeline advances while the buffer has room
  assign en           = ~full;
  assign in_tri.ready = en;

  assign in_word.v0_x = in_tri.v0_x;
  assign in_word.v0_y = in_tri.v0_y;
  assign in_word.v0_z = in_tri.v0_z;
  assign in_word.v1_x = in_tri.v1_x;
  assign in_word.v1_y = in_tri.v1_y;
  assign in_word.v1_z = in_tri.v1_z;
  assign in_word.v2_x = in_tri.v2_x;
  assign in_word.v2_y = in_tri.v2_y;
  assign in_word.v2_z = in_tri.v2_z;

  tun_cross u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tri.valid),
    .in_word   (in_word),
    .out_valid (cr_valid),
    .res       (cres)
  );

  // One divider and square root lane per component
  for (genvar i = 0; i < 3; i++) begin : g_lane
    tun_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cr_valid),
      .num       (cres.sq[i]),
      .den       (cres.s),
      .side_in   ({cres.neg[i], cres.degen}),
      .out_valid (dv[i]),
      .quo       (quo[i]),
      .side_out  (dside[i])
    );

    tun_sqrt u_sqrt (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv[i]),
      .rad       (quo[i]),
      .side_in   (dside[i]),
      .out_valid (sv[i]),
      .root      (root[i]),
      .side_out  (sside[i])
    );
  end

  // Rounding, clamp and sign
  assign wdata.x     = tun_pkg::make_normal(root[0], sside[0]);
  assign wdata.y     = tun_pkg::make_normal(root[1], sside[1]);
  assign wdata.z     = tun_pkg::make_normal(root[2], sside[2]);
  assign wdata.degen = sside[0].degen;
  assign push        = en & (&sv);

  tun_obuf u_obuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wdata   (wdata),
    .full    (full),
    .out_nrm (out_nrm)
  );

endmodule
